// ===== rtl/tricubic_spline_evaluator_macros.svh =====
// Assertion helpers for the tricubic spline evaluator.
// Each macro expects clk and rst_n to be in scope.
`ifndef TRICUBIC_SPLINE_EVALUATOR_MACROS_SVH
`define TRICUBIC_SPLINE_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/tse_pkg.sv =====
`default_nettype none

package tse_pkg;

  localparam int unsigned CELLS_X_DEF = 8;
  localparam int unsigned CELLS_Y_DEF = 8;
  localparam int unsigned CELLS_Z_DEF = 8;

  localparam int unsigned STORE_AW    = 15;
  localparam int unsigned STORE_DEPTH = 32768;
  localparam int unsigned COEFF_W     = 32;
  localparam int unsigned CELL_W      = 6;

  localparam logic signed [47:0] VAL_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] VAL_MIN = {1'b1, {47{1'b0}}};
  localparam logic [80:0]        MAG_MAX = 81'h7FFF_FFFF_FFFF;
  localparam logic [80:0]        MAG_NEG = 81'h8000_0000_0000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_Z_ORIGIN   = 3'd2,
    CFG_X_INV_STEP = 3'd3,
    CFG_Y_INV_STEP = 3'd4,
    CFG_Z_INV_STEP = 3'd5
  } cfg_reg_t;

  localparam logic [3:0] KIND_VALUE = 4'd0;
  localparam logic [3:0] KIND_DX    = 4'd1;
  localparam logic [3:0] KIND_DY    = 4'd2;
  localparam logic [3:0] KIND_DZ    = 4'd3;
  localparam logic [3:0] KIND_DXY   = 4'd4;
  localparam logic [3:0] KIND_DXZ   = 4'd5;
  localparam logic [3:0] KIND_DYZ   = 4'd6;
  localparam logic [3:0] KIND_DXX   = 4'd7;
  localparam logic [3:0] KIND_DYY   = 4'd8;
  localparam logic [3:0] KIND_DZZ   = 4'd9;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         deriv_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [14:0]        coeff_index;
    logic signed [31:0] coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0] ox;
    logic [1:0] oy;
    logic [1:0] oz;
  } order_t;

  typedef struct packed {
    logic signed [47:0] v;
    logic               sat;
  } clip_t;

  function automatic order_t kind_order(input logic [3:0] k);
    order_t o;
    o = '0;
    case (k)
      KIND_DX:  o.ox = 2'd1;
      KIND_DY:  o.oy = 2'd1;
      KIND_DZ:  o.oz = 2'd1;
      KIND_DXY: begin o.ox = 2'd1; o.oy = 2'd1; end
      KIND_DXZ: begin o.ox = 2'd1; o.oz = 2'd1; end
      KIND_DYZ: begin o.oy = 2'd1; o.oz = 2'd1; end
      KIND_DXX: o.ox = 2'd2;
      KIND_DYY: o.oy = 2'd2;
      KIND_DZZ: o.oz = 2'd2;
      default:  o = '0;
    endcase
    return o;
  endfunction

  // Factor that the d-th derivative puts on the power n term.
  function automatic logic [2:0] power_factor(input logic [1:0] d, input logic [1:0] n);
    logic [2:0] f;
    case (d)
      2'd0:    f = 3'd1;
      2'd1:    f = {1'b0, n};
      2'd2:    f = (n == 2'd2) ? 3'd2 : ((n == 2'd3) ? 3'd6 : 3'd0);
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic signed [51:0] scale(input logic signed [47:0] v,
                                               input logic [2:0] f);
    logic signed [51:0] ve;
    logic signed [3:0]  fe;
    ve = {{4{v[47]}}, v};
    fe = {1'b0, f};
    return ve * fe;
  endfunction

  function automatic clip_t clip48(input logic signed [51:0] x);
    clip_t c;
    if (!x[51] && (|x[50:47])) begin
      c.v = VAL_MAX;
      c.sat = 1'b1;
    end else if (x[51] && !(&x[50:47])) begin
      c.v = VAL_MIN;
      c.sat = 1'b1;
    end else begin
      c.v = x[47:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  // Rounds a magnitude with 16 fraction bits half away from zero, applies
  // the sign and saturates to 48 bits.
  function automatic clip_t round_mag(input logic neg, input logic [95:0] p);
    clip_t      c;
    logic [80:0] q;
    q = {1'b0, p[95:16]} + 81'(p[15]);
    c.sat = 1'b0;
    if (neg) begin
      if (q > MAG_NEG) begin
        c.v = VAL_MIN;
        c.sat = 1'b1;
      end else begin
        c.v = -q[47:0];
      end
    end else begin
      if (q > MAG_MAX) begin
        c.v = VAL_MAX;
        c.sat = 1'b1;
      end else begin
        c.v = q[47:0];
      end
    end
    return c;
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] a);
    return a[47] ? -a : a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tse_ram.sv =====
`default_nettype none

module tse_ram #(
  parameter int unsigned WIDTH = tse_pkg::COEFF_W,
  parameter int unsigned DEPTH = tse_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tricubic_spline_evaluator.sv =====
// Tricubic spline evaluator.
// Input channel (in_valid/in_ready/in_data): a write item (cmd 0) stores one
// coefficient and gives no result; an evaluate item (cmd 1) gives one result
// on the output channel (out_valid/out_ready/out_data).
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and sets the grid origins and inverse steps; write it only when idle.
// How long an evaluation takes from its input transfer to out_valid depends
// on the derivative kind. Every 48 x 48 bit product goes through one shared
// 24 x 24 bit multiplier in four passes. For a plain value each of the 64
// coefficients is fetched from a single read port and folded in by one
// Horner step; a derivative in z fetches only the powers of z it keeps. The
// input is ready again in the same cycle that the result is loaded.
// The input is not ready while an evaluation runs. The result waits in an
// output register, so a new item is taken while the receiver stalls; only the
// next result holds back until the previous transfer has completed.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// out_valid and restores the configuration defaults. The coefficient store
// is not cleared and must be loaded before use.
`default_nettype none
`include "tricubic_spline_evaluator_macros.svh"

module tricubic_spline_evaluator #(
  parameter int unsigned CELLS_X = tse_pkg::CELLS_X_DEF,
  parameter int unsigned CELLS_Y = tse_pkg::CELLS_Y_DEF,
  parameter int unsigned CELLS_Z = tse_pkg::CELLS_Z_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tse_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOC   = 14'b00000000000010,
    S_MUL   = 14'b00000000000100,
    S_CELL  = 14'b00000000001000,
    S_ROUND = 14'b00000000010000,
    S_ZRD   = 14'b00000000100000,
    S_ZTERM = 14'b00000001000000,
    S_ADD   = 14'b00000010000000,
    S_YTERM = 14'b00000100000000,
    S_MADV  = 14'b00001000000000,
    S_XTERM = 14'b00010000000000,
    S_LADV  = 14'b00100000000000,
    S_POST  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  typedef enum logic [4:0] {
    LV_LOC  = 5'b00001,
    LV_Z    = 5'b00010,
    LV_Y    = 5'b00100,
    LV_X    = 5'b01000,
    LV_POST = 5'b10000
  } level_t;

  state_t state_r, state_nxt;
  level_t level_r;

  logic signed [31:0] x_org_r, y_org_r, z_org_r;
  logic [31:0]        x_inv_r, y_inv_r, z_inv_r;

  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [1:0]         ox_r, oy_r, oz_r;
  logic [1:0]         axis_r;
  logic [tse_pkg::CELL_W-1:0] cx_r, cy_r, cz_r;
  logic signed [47:0] s_x_r, s_y_r, s_z_r;
  logic [1:0]         l_r, m_r, n_r;
  logic signed [47:0] accx_r, accy_r, accz_r;
  logic signed [47:0] term_r, prod_r;
  logic               sat_r;

  logic [47:0]        ma_r, mb_r;
  logic               neg_r;
  logic [95:0]        p_r;
  logic [1:0]         mcnt_r;

  logic                 out_valid_r;
  tse_pkg::out_item_t   out_r;

  logic eval_go, write_go, out_free;
  tse_pkg::order_t kord;

  // Axis selection for locating.
  logic signed [31:0] pos_sel, org_sel;
  logic [31:0]        inv_sel;
  logic [6:0]         cells_sel;
  logic signed [32:0] u_loc;
  logic [32:0]        u_mag;
  logic [63:0]        ip_loc;
  logic [tse_pkg::CELL_W-1:0] cell_c;

  logic [23:0]  a_half, b_half;
  logic [47:0]  pp;
  logic [95:0]  pp_sh;

  tse_pkg::clip_t rnd, zterm, yterm, xterm, sum;
  logic signed [47:0] coef48;
  logic [17:0]  cell_lin;
  logic [tse_pkg::STORE_AW-1:0] raddr;
  logic [tse_pkg::COEFF_W-1:0]  rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign eval_go  = in_valid && in_ready && (in_data.cmd == tse_pkg::CMD_EVAL);
  assign write_go = in_valid && in_ready && (in_data.cmd == tse_pkg::CMD_WRITE);
  assign out_free = !out_valid_r || out_ready;
  assign kord     = tse_pkg::kind_order(in_data.deriv_kind);

  always_comb begin
    case (axis_r)
      2'd0: begin
        pos_sel = pos_x_r; org_sel = x_org_r; inv_sel = x_inv_r; cells_sel = 7'(CELLS_X);
      end
      2'd1: begin
        pos_sel = pos_y_r; org_sel = y_org_r; inv_sel = y_inv_r; cells_sel = 7'(CELLS_Y);
      end
      default: begin
        pos_sel = pos_z_r; org_sel = z_org_r; inv_sel = z_inv_r; cells_sel = 7'(CELLS_Z);
      end
    endcase
  end

  assign u_loc  = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
  assign u_mag  = u_loc[32] ? 33'(-u_loc) : 33'(u_loc);
  assign ip_loc = p_r[95:32];

  // Cell index: truncation toward zero, clamped to the grid; negative offsets
  // stay in cell zero.
  always_comb begin
    if (neg_r) begin
      cell_c = '0;
    end else if (ip_loc >= 64'(cells_sel)) begin
      cell_c = tse_pkg::CELL_W'(cells_sel - 7'd1);
    end else begin
      cell_c = ip_loc[tse_pkg::CELL_W-1:0];
    end
  end

  // One partial product of the shared multiplier per cycle.
  assign a_half = mcnt_r[1] ? ma_r[47:24] : ma_r[23:0];
  assign b_half = mcnt_r[0] ? mb_r[47:24] : mb_r[23:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (2'(mcnt_r[1]) + 2'(mcnt_r[0]))
      2'd0:    pp_sh = 96'(pp);
      2'd1:    pp_sh = 96'(pp) << 24;
      default: pp_sh = 96'(pp) << 48;
    endcase
  end

  assign rnd    = tse_pkg::round_mag(neg_r, p_r);
  assign coef48 = {{16{rdata[31]}}, rdata};
  assign zterm  = tse_pkg::clip48(tse_pkg::scale(coef48, tse_pkg::power_factor(oz_r, n_r)));
  assign yterm  = tse_pkg::clip48(tse_pkg::scale(accz_r, tse_pkg::power_factor(oy_r, m_r)));
  assign xterm  = tse_pkg::clip48(tse_pkg::scale(accy_r, tse_pkg::power_factor(ox_r, l_r)));
  assign sum    = tse_pkg::clip48({{4{prod_r[47]}}, prod_r} + {{4{term_r[47]}}, term_r});

  // Coefficient address: the cell number wraps into the store.
  assign cell_lin = 18'((32'(cx_r) * CELLS_Y + 32'(cy_r)) * CELLS_Z + 32'(cz_r));
  assign raddr    = {cell_lin[8:0], l_r, m_r, n_r};

  tse_ram #(
    .WIDTH (tse_pkg::COEFF_W),
    .DEPTH (tse_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (write_go),
    .waddr (in_data.coeff_index),
    .wdata (in_data.coeff_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (eval_go) state_nxt = S_LOC;
      S_LOC:   state_nxt = S_MUL;
      S_MUL:   if (mcnt_r == 2'd3) state_nxt = (level_r == LV_LOC) ? S_CELL : S_ROUND;
      S_CELL:  state_nxt = S_ROUND;
      S_ROUND: begin
        if (level_r == LV_LOC) begin
          state_nxt = (axis_r == 2'd2) ? S_ZRD : S_LOC;
        end else if (level_r == LV_POST) begin
          state_nxt = S_POST;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_ZRD:   state_nxt = S_ZTERM;
      S_ZTERM: state_nxt = S_MUL;
      S_ADD: begin
        case (level_r)
          LV_Z:    state_nxt = (n_r == oz_r) ? S_YTERM : S_ZRD;
          LV_Y:    state_nxt = S_MADV;
          default: state_nxt = S_LADV;
        endcase
      end
      S_YTERM: state_nxt = (m_r >= oy_r) ? S_MUL : S_MADV;
      S_MADV:  state_nxt = (m_r == 2'd0) ? S_XTERM : S_ZRD;
      S_XTERM: state_nxt = (l_r >= ox_r) ? S_MUL : S_LADV;
      S_LADV:  state_nxt = (l_r == 2'd0) ? S_POST : S_ZRD;
      S_POST: begin
        if ((ox_r != 2'd0) || (oy_r != 2'd0) || (oz_r != 2'd0)) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= 2'd0;
      out_valid_r <= 1'b0;
      x_org_r     <= '0;
      y_org_r     <= '0;
      z_org_r     <= '0;
      x_inv_r     <= 32'd65536;
      y_inv_r     <= 32'd65536;
      z_inv_r     <= 32'd65536;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MUL) begin
        mcnt_r <= mcnt_r + 2'd1;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (tse_pkg::cfg_reg_t'(cfg_index))
          tse_pkg::CFG_X_ORIGIN:   x_org_r <= cfg_data;
          tse_pkg::CFG_Y_ORIGIN:   y_org_r <= cfg_data;
          tse_pkg::CFG_Z_ORIGIN:   z_org_r <= cfg_data;
          tse_pkg::CFG_X_INV_STEP: x_inv_r <= cfg_data;
          tse_pkg::CFG_Y_INV_STEP: y_inv_r <= cfg_data;
          tse_pkg::CFG_Z_INV_STEP: z_inv_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (eval_go) begin
          pos_x_r <= in_data.pos_x;
          pos_y_r <= in_data.pos_y;
          pos_z_r <= in_data.pos_z;
          ox_r    <= kord.ox;
          oy_r    <= kord.oy;
          oz_r    <= kord.oz;
          axis_r  <= 2'd0;
          l_r     <= 2'd3;
          m_r     <= 2'd3;
          n_r     <= 2'd3;
          accx_r  <= '0;
          accy_r  <= '0;
          accz_r  <= '0;
          sat_r   <= 1'b0;
        end
      end
      S_LOC: begin
        ma_r    <= 48'(u_mag);
        mb_r    <= 48'(inv_sel);
        neg_r   <= u_loc[32];
        p_r     <= '0;
        level_r <= LV_LOC;
      end
      S_MUL: p_r <= p_r + pp_sh;
      S_CELL: begin
        p_r <= p_r - (96'(cell_c) << 32);
        case (axis_r)
          2'd0:    cx_r <= cell_c;
          2'd1:    cy_r <= cell_c;
          default: cz_r <= cell_c;
        endcase
      end
      S_ROUND: begin
        sat_r <= sat_r | rnd.sat;
        if (level_r == LV_LOC) begin
          case (axis_r)
            2'd0:    s_x_r <= rnd.v;
            2'd1:    s_y_r <= rnd.v;
            default: s_z_r <= rnd.v;
          endcase
          axis_r <= axis_r + 2'd1;
        end else if (level_r == LV_POST) begin
          accx_r <= rnd.v;
        end else begin
          prod_r <= rnd.v;
        end
      end
      S_ZTERM: begin
        term_r  <= zterm.v;
        sat_r   <= sat_r | zterm.sat;
        ma_r    <= tse_pkg::mag48(accz_r);
        mb_r    <= tse_pkg::mag48(s_z_r);
        neg_r   <= accz_r[47] ^ s_z_r[47];
        p_r     <= '0;
        level_r <= LV_Z;
      end
      S_ADD: begin
        sat_r <= sat_r | sum.sat;
        case (level_r)
          LV_Z: begin
            accz_r <= sum.v;
            if (n_r != oz_r) begin
              n_r <= n_r - 2'd1;
            end
          end
          LV_Y:    accy_r <= sum.v;
          default: accx_r <= sum.v;
        endcase
      end
      S_YTERM: begin
        if (m_r >= oy_r) begin
          term_r  <= yterm.v;
          sat_r   <= sat_r | yterm.sat;
          ma_r    <= tse_pkg::mag48(accy_r);
          mb_r    <= tse_pkg::mag48(s_y_r);
          neg_r   <= accy_r[47] ^ s_y_r[47];
          p_r     <= '0;
          level_r <= LV_Y;
        end
      end
      S_MADV: begin
        if (m_r != 2'd0) begin
          m_r    <= m_r - 2'd1;
          n_r    <= 2'd3;
          accz_r <= '0;
        end
      end
      S_XTERM: begin
        if (l_r >= ox_r) begin
          term_r  <= xterm.v;
          sat_r   <= sat_r | xterm.sat;
          ma_r    <= tse_pkg::mag48(accx_r);
          mb_r    <= tse_pkg::mag48(s_x_r);
          neg_r   <= accx_r[47] ^ s_x_r[47];
          p_r     <= '0;
          level_r <= LV_X;
        end
      end
      S_LADV: begin
        if (l_r != 2'd0) begin
          l_r    <= l_r - 2'd1;
          m_r    <= 2'd3;
          n_r    <= 2'd3;
          accz_r <= '0;
          accy_r <= '0;
        end
      end
      S_POST: begin
        // Scale once by the inverse step for each derivative order.
        ma_r    <= tse_pkg::mag48(accx_r);
        neg_r   <= accx_r[47];
        p_r     <= '0;
        level_r <= LV_POST;
        if (ox_r != 2'd0) begin
          ox_r <= ox_r - 2'd1;
          mb_r <= 48'(x_inv_r);
        end else if (oy_r != 2'd0) begin
          oy_r <= oy_r - 2'd1;
          mb_r <= 48'(y_inv_r);
        end else begin
          if (oz_r != 2'd0) begin
            oz_r <= oz_r - 2'd1;
          end
          mb_r <= 48'(z_inv_r);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_r.value     <= accx_r;
          out_r.saturated <= sat_r;
        end
      end
      default: ;
    endcase
  end

  `TSE_ASSERT_NEXT(a_eval_starts, eval_go, state_r == S_LOC, "evaluate transfer did not start locating")
  `TSE_ASSERT_NEXT(a_write_stays_idle, write_go, state_r == S_IDLE && out_valid_r == $past(out_valid_r && !out_ready), "write transfer disturbed sequencer or output")
  `TSE_ASSERT_NEXT(a_result_loaded, state_r == S_OUT && out_free, out_valid_r && state_r == S_IDLE, "finished evaluation did not reach the output register")
  `TSE_ASSERT_IMPLY(a_mul_count_idle, state_r != S_MUL, mcnt_r == 2'd0, "multiplier pass count out of step")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int GRID_X = 8;
  localparam int GRID_Y = 8;
  localparam int GRID_Z = 8;
  localparam int DRAIN_CYCLES = 1000;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tse_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tse_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] coeff_mem [tse_pkg::STORE_DEPTH];
  logic [31:0] grid_cfg [6];
  bit cell_ready [GRID_X * GRID_Y * GRID_Z];
  tse_pkg::out_item_t pending_results[$];
  int err_count = 0;
  int cycles = 0;
  int hold_left = 0;
  bit idle_en = 1'b1;

  tricubic_spline_evaluator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
    $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
    err_count++;
  endtask

  function automatic longint clip_q(input longint x, inout bit sat);
    if (x > Q_MAX) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (x < Q_MIN) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return x;
  endfunction

  function automatic longint signed_from_mag(input bit neg, input logic [127:0] q,
                                             inout bit sat);
    if (neg) begin
      if (q > 128'h8000_0000_0000) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return -longint'(q[63:0]);
    end
    if (q > 128'h7FFF_FFFF_FFFF) begin
      sat = 1'b1;
      return Q_MAX;
    end
    return longint'(q[63:0]);
  endfunction

  // Exact product of two Q32.16 values, rounded half away from zero.
  function automatic longint fixed_mul(input longint a, input longint b, inout bit sat);
    logic [127:0] ma, mb, p, q;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = {64'd0, (a < 0) ? -a : a};
    mb = {64'd0, (b < 0) ? -b : b};
    p = ma * mb;
    q = (p >> 16) + p[15];
    return signed_from_mag(neg, q, sat);
  endfunction

  function automatic longint cell_offset(input logic [31:0] pos, input logic [31:0] org,
                                         input logic [31:0] inv, input int cells,
                                         output int cell_idx, inout bit sat);
    longint u;
    logic [127:0] t, m, q;
    bit neg;
    u = longint'($signed(pos)) - longint'($signed(org));
    neg = u < 0;
    t = {64'd0, neg ? -u : u} * {96'd0, inv};
    cell_idx = 0;
    if (!neg) cell_idx = ((t >> 32) >= cells) ? cells - 1 : int'(t >> 32);
    m = t - (128'(cell_idx) << 32);
    q = (m >> 16) + m[15];
    return signed_from_mag(neg, q, sat);
  endfunction

  function automatic longint deriv_horner(input longint v[4], input int d,
                                          input longint s, inout bit sat);
    longint acc, term, f;
    acc = 0;
    for (int n = 3; n >= d; n--) begin
      f = (d == 0) ? 1 : ((d == 1) ? n : n * (n - 1));
      term = clip_q(v[n] * f, sat);
      acc = clip_q(fixed_mul(acc, s, sat) + term, sat);
    end
    return acc;
  endfunction

  function automatic void apply_item(input tse_pkg::in_item_t it);
    int ox, oy, oz, ci, cj, ck, base;
    longint sx, sy, sz, res;
    longint zv[4], yv[4], xv[4];
    bit sat;
    tse_pkg::out_item_t r;
    if (it.cmd == tse_pkg::CMD_WRITE) begin
      coeff_mem[it.coeff_index] = it.coeff_value;
      return;
    end
    ox = 0; oy = 0; oz = 0; sat = 1'b0;
    case (it.deriv_kind)
      tse_pkg::KIND_DX: ox = 1;
      tse_pkg::KIND_DY: oy = 1;
      tse_pkg::KIND_DZ: oz = 1;
      tse_pkg::KIND_DXY: begin ox = 1; oy = 1; end
      tse_pkg::KIND_DXZ: begin ox = 1; oz = 1; end
      tse_pkg::KIND_DYZ: begin oy = 1; oz = 1; end
      tse_pkg::KIND_DXX: ox = 2;
      tse_pkg::KIND_DYY: oy = 2;
      tse_pkg::KIND_DZZ: oz = 2;
      default: ;
    endcase
    sx = cell_offset(it.pos_x, grid_cfg[tse_pkg::CFG_X_ORIGIN],
                     grid_cfg[tse_pkg::CFG_X_INV_STEP], GRID_X, ci, sat);
    sy = cell_offset(it.pos_y, grid_cfg[tse_pkg::CFG_Y_ORIGIN],
                     grid_cfg[tse_pkg::CFG_Y_INV_STEP], GRID_Y, cj, sat);
    sz = cell_offset(it.pos_z, grid_cfg[tse_pkg::CFG_Z_ORIGIN],
                     grid_cfg[tse_pkg::CFG_Z_INV_STEP], GRID_Z, ck, sat);
    base = ((ci * GRID_Y + cj) * GRID_Z + ck) * 64;
    for (int l = 0; l < 4; l++) begin
      for (int m = 0; m < 4; m++) begin
        for (int n = 0; n < 4; n++)
          zv[n] = longint'($signed(
                    coeff_mem[(base + 16 * l + 4 * m + n) % tse_pkg::STORE_DEPTH]));
        yv[m] = deriv_horner(zv, oz, sz, sat);
      end
      xv[l] = deriv_horner(yv, oy, sy, sat);
    end
    res = deriv_horner(xv, ox, sx, sat);
    for (int k = 0; k < ox; k++)
      res = fixed_mul(res, longint'({32'd0, grid_cfg[tse_pkg::CFG_X_INV_STEP]}), sat);
    for (int k = 0; k < oy; k++)
      res = fixed_mul(res, longint'({32'd0, grid_cfg[tse_pkg::CFG_Y_INV_STEP]}), sat);
    for (int k = 0; k < oz; k++)
      res = fixed_mul(res, longint'({32'd0, grid_cfg[tse_pkg::CFG_Z_INV_STEP]}), sat);
    r.value = res[47:0];
    r.saturated = sat;
    pending_results.push_back(r);
  endfunction

  // Result checker and receiver-side stalls.
  initial begin
    out_result_loop: forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data.value);
        end else begin
          tse_pkg::out_item_t want;
          want = pending_results.pop_front();
          if (out_data.value !== want.value)
            report_mismatch("value", want.value, out_data.value);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 48'(want.saturated), 48'(out_data.saturated));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_en && $urandom_range(99) < 25);
      end
    end
  end

  task automatic send_item(input tse_pkg::in_item_t it);
    while (idle_en && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    apply_item(it);
  endtask

  task automatic write_reg(input tse_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    grid_cfg[idx] = val;
  endtask

  // Writes no result, so the last write may still be in flight; allow for it.
  task automatic drain;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic tse_pkg::in_item_t write_item(input logic [14:0] idx,
                                                   input logic [31:0] val);
    tse_pkg::in_item_t it;
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(tse_pkg::in_item_t)-1:0];
    it.cmd = tse_pkg::CMD_WRITE;
    it.coeff_index = idx;
    it.coeff_value = val;
    return it;
  endfunction

  function automatic tse_pkg::in_item_t eval_item(input logic [3:0] kind,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
    tse_pkg::in_item_t it;
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(tse_pkg::in_item_t)-1:0];
    it.cmd = tse_pkg::CMD_EVAL;
    it.deriv_kind = kind;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic logic [31:0] small_coeff;
    return $urandom_range(99) < 10 ? $urandom : 32'($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic logic [31:0] grid_pos(input logic [31:0] org);
    if ($urandom_range(99) < 15) return $urandom;
    return org + 32'($urandom_range(0, 12 << 16)) - (2 << 16);
  endfunction

  // True when the point lands in a cell whose coefficients are all loaded.
  function automatic bit cell_loaded_at(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
    int ci, cj, ck;
    bit sat;
    sat = 1'b0;
    void'(cell_offset(x, grid_cfg[tse_pkg::CFG_X_ORIGIN],
                      grid_cfg[tse_pkg::CFG_X_INV_STEP], GRID_X, ci, sat));
    void'(cell_offset(y, grid_cfg[tse_pkg::CFG_Y_ORIGIN],
                      grid_cfg[tse_pkg::CFG_Y_INV_STEP], GRID_Y, cj, sat));
    void'(cell_offset(z, grid_cfg[tse_pkg::CFG_Z_ORIGIN],
                      grid_cfg[tse_pkg::CFG_Z_INV_STEP], GRID_Z, ck, sat));
    return cell_ready[(ci * GRID_Y + cj) * GRID_Z + ck];
  endfunction

  // The grid origin itself always falls in the first cell, which is loaded.
  function automatic tse_pkg::in_item_t random_eval(input logic [3:0] kind);
    logic [31:0] x, y, z;
    for (int tries = 0; tries < 64; tries++) begin
      x = grid_pos(grid_cfg[tse_pkg::CFG_X_ORIGIN]);
      y = grid_pos(grid_cfg[tse_pkg::CFG_Y_ORIGIN]);
      z = grid_pos(grid_cfg[tse_pkg::CFG_Z_ORIGIN]);
      if (cell_loaded_at(x, y, z)) return eval_item(kind, x, y, z);
    end
    return eval_item(kind, grid_cfg[tse_pkg::CFG_X_ORIGIN],
                     grid_cfg[tse_pkg::CFG_Y_ORIGIN], grid_cfg[tse_pkg::CFG_Z_ORIGIN]);
  endfunction

  function automatic tse_pkg::in_item_t random_item;
    logic [3:0] kind;
    if ($urandom_range(99) < 35) return write_item(15'($urandom), small_coeff());
    kind = $urandom_range(99) < 90 ? 4'($urandom_range(9)) : 4'($urandom_range(15));
    return random_eval(kind);
  endfunction

  task automatic load_cell(input int c);
    for (int w = 0; w < 64; w++) send_item(write_item(15'(c * 64 + w), small_coeff()));
    cell_ready[c] = 1'b1;
  endtask

  // Evaluations only visit the first cell, the cell one step along y and the
  // last cell, so only those are loaded.
  task automatic test_load_store;
    load_cell(0);
    load_cell(GRID_Z);
    load_cell(GRID_X * GRID_Y * GRID_Z - 1);
    drain();
  endtask

  task automatic test_directed;
    send_item(write_item(15'd0, 32'h8000_0000));
    send_item(write_item(15'd63, 32'h7FFF_FFFF));
    send_item(write_item(15'h7FFF, 32'h7FFF_FFFF));
    send_item(write_item(15'h7FC0, 32'h8000_0000));
    for (int k = 0; k < 16; k++)
      send_item(eval_item(4'(k), 32'(k & 1) << 15, 32'h0001_8000, 32'h0000_4000));
    send_item(eval_item(tse_pkg::KIND_VALUE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(eval_item(tse_pkg::KIND_VALUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(eval_item(tse_pkg::KIND_DXX, 32'h0007_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(eval_item(tse_pkg::KIND_DZZ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0008_0000));
    drain();
  endtask

  task automatic test_config_sweep;
    logic [31:0] settings [4][6];
    settings[0] = '{32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
                    32'h0002_0000, 32'h0002_0000, 32'h0002_0000};
    settings[1] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0};
    settings[2] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    settings[3] = '{$urandom, $urandom, $urandom,
                    32'($urandom_range(1 << 12, 1 << 18)), 32'($urandom_range(1 << 12, 1 << 18)),
                    32'($urandom_range(1 << 12, 1 << 18))};
    for (int s = 0; s < 4; s++) begin
      for (int r = 0; r < 6; r++) write_reg(tse_pkg::cfg_reg_t'(r), settings[s][r]);
      drain();
      for (int i = 0; i < 60; i++) send_item(random_item());
      drain();
    end
  endtask

  // A long receiver stall fills the output register and blocks the input.
  task automatic test_backpressure;
    idle_en = 1'b0;
    hold_left = 3000;
    for (int i = 0; i < 8; i++)
      send_item(random_eval(4'($urandom_range(9))));
    idle_en = 1'b1;
    drain();
  endtask

  task automatic test_random;
    write_reg(tse_pkg::CFG_X_ORIGIN, 32'h0);
    write_reg(tse_pkg::CFG_Y_ORIGIN, 32'hFFFF_0000);
    write_reg(tse_pkg::CFG_Z_ORIGIN, 32'h0000_8000);
    write_reg(tse_pkg::CFG_X_INV_STEP, 32'h0001_0000);
    write_reg(tse_pkg::CFG_Y_INV_STEP, 32'h0000_C000);
    write_reg(tse_pkg::CFG_Z_INV_STEP, 32'h0001_8000);
    drain();
    for (int i = 0; i < 440; i++) begin
      idle_en = !(i >= 200 && i < 300);
      send_item(random_item());
    end
    idle_en = 1'b1;
    drain();
  endtask

  initial begin
    grid_cfg = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_store();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
